@@ sv/baf_pkg.sv @@
// ============================================================================
// baf_pkg
// Shared constants, codes and control structs for the bridge finder.
// ============================================================================
package baf_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int MAX_EDGES_DEF    = 64;

    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_BUILD  = 3'd1;
    localparam logic [2:0] ACT_BQUERY = 3'd2;
    localparam logic [2:0] ACT_VQUERY = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    localparam logic [2:0] REC_ACK    = 3'd0;
    localparam logic [2:0] REC_ART    = 3'd1;
    localparam logic [2:0] REC_BRIDGE = 3'd2;
    localparam logic [2:0] REC_DONE   = 3'd3;
    localparam logic [2:0] REC_BANS   = 3'd4;
    localparam logic [2:0] REC_VINFO  = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SELF  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [4:0] NUM_VERT_RESET = 5'd16;

    // controller -> datapath commands
    typedef struct packed {
        logic op_add;
        logic op_clear;
        logic op_simple;
        logic bld_init;
        logic root_step;
        logic scan_step;
        logic emit_art_step;
        logic emit_br_step;
        logic emit_done;
    } ctl_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic root_done;
        logic dfs_idle;
        logic art_done;
        logic br_done;
        logic out_busy;
    } dp_stat_t;

endpackage

@@ sv/baf_ctrl.sv @@
// ============================================================================
// baf_ctrl
// Sequencer for one input item: decode, search phases, output phases.
// ============================================================================
module baf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        action,
    input  baf_pkg::dp_stat_t stat,
    output baf_pkg::ctl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ROOT = 3'd1;
    localparam logic [2:0] S_DFS  = 3'd2;
    localparam logic [2:0] S_ART  = 3'd3;
    localparam logic [2:0] S_BR   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       acc;

    assign in_ready = (state_reg == S_IDLE) && !stat.out_busy;
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (action == baf_pkg::ACT_BUILD)
                    begin
                        cmd.bld_init = 1'b1;
                        state_next   = S_ROOT;
                    end
                    else if (action == baf_pkg::ACT_ADD)
                        cmd.op_add = 1'b1;
                    else if (action == baf_pkg::ACT_CLEAR)
                        cmd.op_clear = 1'b1;
                    else
                        cmd.op_simple = 1'b1;
                end
            end
            S_ROOT:
            begin
                if (stat.root_done)
                    state_next = S_ART;
                else
                begin
                    cmd.root_step = 1'b1;
                    state_next    = S_DFS;
                end
            end
            S_DFS:
            begin
                if (stat.dfs_idle)
                    state_next = S_ROOT;
                else
                    cmd.scan_step = 1'b1;
            end
            S_ART:
            begin
                if (!stat.out_busy)
                begin
                    if (stat.art_done)
                        state_next = S_BR;
                    else
                        cmd.emit_art_step = 1'b1;
                end
            end
            S_BR:
            begin
                if (!stat.out_busy)
                begin
                    if (stat.br_done)
                        state_next = S_DONE;
                    else
                        cmd.emit_br_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ sv/baf_datapath.sv @@
// ============================================================================
// baf_datapath
// Edge store, vertex tables, search stack, bridge matrix and output register.
// ============================================================================
module baf_datapath
#(
    parameter int MAX_VERTICES = baf_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = baf_pkg::MAX_EDGES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  baf_pkg::ctl_cmd_t cmd,
    output baf_pkg::dp_stat_t stat,
    input  logic [2:0]        action,
    input  logic [3:0]        vert_a,
    input  logic [3:0]        vert_b,
    input  logic [4:0]        num_vertices,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        record_kind,
    output logic [1:0]        status,
    output logic [3:0]        vert_lo,
    output logic [3:0]        vert_hi,
    output logic signed [4:0] order,
    output logic [3:0]        low_link,
    output logic signed [4:0] parent,
    output logic              is_cut,
    output logic              bridge_answer,
    output logic              last
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int KW = $clog2(MAX_EDGES + 1);
    localparam int OW = VW + 1;
    localparam logic [OW-1:0] NEG1 = '1;

    // effective vertex count
    logic [CW-1:0] n_eff;
    always_comb
    begin
        if (num_vertices == 5'd0)
            n_eff = CW'(1);
        else if (32'(num_vertices) > MAX_VERTICES)
            n_eff = CW'(MAX_VERTICES);
        else
            n_eff = CW'(num_vertices);
    end

    logic [7:0] ea_x;
    logic [7:0] eb_x;
    assign ea_x = 8'(vert_a);
    assign eb_x = 8'(vert_b);
    logic a_oor;
    logic b_oor;
    assign a_oor = 32'(vert_a) >= 32'(n_eff);
    assign b_oor = 32'(vert_b) >= 32'(n_eff);

    // edge store memory
    logic [VW-1:0] emem_a [MAX_EDGES];
    logic [VW-1:0] emem_b [MAX_EDGES];
    logic [KW-1:0] ecount_reg;
    logic [VW-1:0] rd_a_reg;
    logic [VW-1:0] rd_b_reg;

    // vertex tables
    logic [OW-1:0] ord_reg [MAX_VERTICES];
    logic [VW-1:0] low_reg [MAX_VERTICES];
    logic [OW-1:0] par_reg [MAX_VERTICES];
    logic          cut_reg [MAX_VERTICES];
    logic [VW-1:0] vcnt_reg;
    logic [MAX_VERTICES-1:0] brm_reg [MAX_VERTICES];

    // search stack
    logic [VW-1:0] sv_reg  [MAX_VERTICES];
    logic [EW:0]   spe_reg [MAX_VERTICES];
    logic [KW-1:0] snx_reg [MAX_VERTICES];
    logic [1:0]    sch_reg [MAX_VERTICES];
    logic          sar_reg [MAX_VERTICES];
    logic [CW-1:0] sp_reg;

    // scan pipeline: phase 0 issue read, phase 1 evaluate
    logic          ph_reg;
    logic [CW-1:0] root_reg;
    logic [CW-1:0] emit_reg;
    logic [VW-1:0] brow_reg;
    logic [VW-1:0] bcol_reg;
    logic          bdone_reg;

    // output register
    logic          ov_reg;
    logic [2:0]    kind_reg;
    logic [1:0]    st_reg;
    logic [3:0]    lo_reg;
    logic [3:0]    hi_reg;
    logic [4:0]    oo_reg;
    logic [3:0]    ol_reg;
    logic [4:0]    op_reg;
    logic          oc_reg;
    logic          oa_reg;
    logic          ol_last_reg;

    assign out_valid     = ov_reg;
    assign record_kind   = kind_reg;
    assign status        = st_reg;
    assign vert_lo       = lo_reg;
    assign vert_hi       = hi_reg;
    assign order         = oo_reg;
    assign low_link      = ol_reg;
    assign parent        = op_reg;
    assign is_cut        = oc_reg;
    assign bridge_answer = oa_reg;
    assign last          = ol_last_reg;

    // top frame
    logic [VW-1:0] top;
    logic [VW-1:0] tv;
    logic [EW:0]   tpe;
    logic [KW-1:0] tnx;
    logic          t_root;
    logic [VW-1:0] pidx;
    logic [VW-1:0] pv;
    assign top    = VW'(sp_reg - CW'(1));
    assign pidx   = VW'(sp_reg - CW'(2));
    assign tv     = sv_reg[top];
    assign tpe    = spe_reg[top];
    assign tnx    = snx_reg[top];
    assign t_root = tpe[EW];
    assign pv     = sv_reg[pidx];

    logic e_match;
    logic [VW-1:0] nbr;
    assign e_match = (tpe != {1'b0, EW'(tnx)}) && (32'(rd_a_reg) < 32'(n_eff))
                   && (32'(rd_b_reg) < 32'(n_eff)) && ((rd_a_reg == tv) || (rd_b_reg == tv));
    assign nbr = (rd_a_reg == tv) ? rd_b_reg : rd_a_reg;

    logic [VW-1:0] low_new;
    assign low_new = (low_reg[pv] < low_reg[tv]) ? low_reg[pv] : low_reg[tv];

    logic [VW-1:0] qx;
    logic [VW-1:0] qy;
    logic [VW-1:0] qa;
    logic [VW-1:0] qb;
    assign qa = VW'(vert_a);
    assign qb = VW'(vert_b);
    always_comb
    begin
        if ($signed(ord_reg[qa]) > $signed(ord_reg[qb]))
        begin
            qx = qb;
            qy = qa;
        end
        else
        begin
            qx = qa;
            qy = qb;
        end
    end

    assign stat.root_done = root_reg >= n_eff;
    assign stat.dfs_idle  = sp_reg == '0;
    assign stat.art_done  = emit_reg >= n_eff;
    assign stat.br_done   = bdone_reg;
    assign stat.out_busy  = ov_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.op_add && !a_oor && !b_oor && (vert_a != vert_b)
            && (32'(ecount_reg) < MAX_EDGES))
        begin
            emem_a[EW'(ecount_reg)] <= VW'(ea_x);
            emem_b[EW'(ecount_reg)] <= VW'(eb_x);
        end
        rd_a_reg <= emem_a[EW'(tnx)];
        rd_b_reg <= emem_b[EW'(tnx)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecount_reg <= '0;
            vcnt_reg   <= '0;
            sp_reg     <= '0;
            ph_reg     <= 1'b0;
            root_reg   <= '0;
            emit_reg   <= '0;
            brow_reg   <= '0;
            bcol_reg   <= '0;
            bdone_reg  <= 1'b0;
            ov_reg     <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                ord_reg[i] <= NEG1;
                low_reg[i] <= '0;
                par_reg[i] <= NEG1;
                cut_reg[i] <= 1'b0;
                brm_reg[i] <= '0;
            end
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;

            if (cmd.op_add)
            begin
                ov_reg      <= 1'b1;
                kind_reg    <= baf_pkg::REC_ACK;
                lo_reg <= '0; hi_reg <= '0; oo_reg <= '0; ol_reg <= '0;
                op_reg <= '0; oc_reg <= 1'b0; oa_reg <= 1'b0;
                ol_last_reg <= 1'b1;
                if (a_oor || b_oor)
                    st_reg <= baf_pkg::ST_RANGE;
                else if (vert_a == vert_b)
                    st_reg <= baf_pkg::ST_SELF;
                else if (32'(ecount_reg) >= MAX_EDGES)
                    st_reg <= baf_pkg::ST_FULL;
                else
                begin
                    st_reg     <= baf_pkg::ST_OK;
                    ecount_reg <= ecount_reg + KW'(1);
                end
            end

            if (cmd.op_clear)
            begin
                ecount_reg <= '0;
                vcnt_reg   <= '0;
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    ord_reg[i] <= NEG1;
                    low_reg[i] <= '0;
                    par_reg[i] <= NEG1;
                    cut_reg[i] <= 1'b0;
                end
                ov_reg <= 1'b1; kind_reg <= baf_pkg::REC_ACK; st_reg <= baf_pkg::ST_OK;
                lo_reg <= '0; hi_reg <= '0; oo_reg <= '0; ol_reg <= '0;
                op_reg <= '0; oc_reg <= 1'b0; oa_reg <= 1'b0; ol_last_reg <= 1'b1;
            end

            if (cmd.op_simple)
            begin
                ov_reg <= 1'b1; st_reg <= baf_pkg::ST_OK;
                lo_reg <= '0; hi_reg <= '0; oo_reg <= '0; ol_reg <= '0;
                op_reg <= '0; oc_reg <= 1'b0; oa_reg <= 1'b0; ol_last_reg <= 1'b1;
                kind_reg <= baf_pkg::REC_ACK;
                if (action == baf_pkg::ACT_BQUERY)
                begin
                    kind_reg <= baf_pkg::REC_BANS;
                    if (a_oor || b_oor)
                        st_reg <= baf_pkg::ST_RANGE;
                    else
                        oa_reg <= $signed(ord_reg[qx]) < $signed({1'b0, low_reg[qy]});
                end
                else if (action == baf_pkg::ACT_VQUERY)
                begin
                    kind_reg <= baf_pkg::REC_VINFO;
                    if (a_oor)
                        st_reg <= baf_pkg::ST_RANGE;
                    else
                    begin
                        oo_reg <= 5'($signed(ord_reg[qa]));
                        ol_reg <= 4'(low_reg[qa]);
                        op_reg <= 5'($signed(par_reg[qa]));
                        oc_reg <= cut_reg[qa];
                    end
                end
            end

            if (cmd.bld_init)
            begin
                vcnt_reg  <= '0;
                root_reg  <= '0;
                emit_reg  <= '0;
                brow_reg  <= '0;
                bcol_reg  <= '0;
                bdone_reg <= 1'b0;
                for (int i = 0; i < MAX_VERTICES; i++)
                begin
                    ord_reg[i] <= NEG1;
                    par_reg[i] <= NEG1;
                    cut_reg[i] <= 1'b0;
                    brm_reg[i] <= '0;
                end
            end

            if (cmd.root_step)
            begin
                root_reg <= root_reg + CW'(1);
                if (ord_reg[VW'(root_reg)] == NEG1)
                begin
                    ord_reg[VW'(root_reg)] <= OW'(vcnt_reg);
                    low_reg[VW'(root_reg)] <= vcnt_reg;
                    vcnt_reg <= vcnt_reg + VW'(1);
                    sv_reg[0]  <= VW'(root_reg);
                    spe_reg[0] <= {1'b1, EW'(0)};
                    snx_reg[0] <= '0;
                    sch_reg[0] <= '0;
                    sar_reg[0] <= 1'b0;
                    sp_reg     <= CW'(1);
                    ph_reg     <= 1'b0;
                end
            end

            if (cmd.scan_step && sp_reg != '0)
            begin
                if (!ph_reg)
                begin
                    if (tnx < ecount_reg)
                        ph_reg <= 1'b1;
                    else
                    begin
                        cut_reg[tv] <= sar_reg[top] || (t_root && sch_reg[top] == 2'd2);
                        sp_reg <= sp_reg - CW'(1);
                        if (sp_reg > CW'(1))
                        begin
                            low_reg[pv] <= low_new;
                            if (!spe_reg[pidx][EW] && $signed(ord_reg[pv])
                                <= $signed({1'b0, low_reg[tv]}))
                                sar_reg[pidx] <= 1'b1;
                            if ($signed(ord_reg[pv]) < $signed({1'b0, low_reg[tv]}))
                            begin
                                if (pv < tv)
                                    brm_reg[pv][tv] <= 1'b1;
                                else
                                    brm_reg[tv][pv] <= 1'b1;
                            end
                        end
                    end
                end
                else
                begin
                    ph_reg <= 1'b0;
                    snx_reg[top] <= tnx + KW'(1);
                    if (e_match)
                    begin
                        if (ord_reg[nbr] != NEG1)
                        begin
                            if ($signed(ord_reg[nbr]) < $signed({1'b0, low_reg[tv]}))
                                low_reg[tv] <= VW'(ord_reg[nbr]);
                        end
                        else
                        begin
                            par_reg[nbr] <= {1'b0, tv};
                            if (sch_reg[top] != 2'd2)
                                sch_reg[top] <= sch_reg[top] + 2'd1;
                            ord_reg[nbr] <= OW'(vcnt_reg);
                            low_reg[nbr] <= vcnt_reg;
                            vcnt_reg <= vcnt_reg + VW'(1);
                            sv_reg[VW'(sp_reg)]  <= nbr;
                            spe_reg[VW'(sp_reg)] <= {1'b0, EW'(tnx)};
                            snx_reg[VW'(sp_reg)] <= '0;
                            sch_reg[VW'(sp_reg)] <= '0;
                            sar_reg[VW'(sp_reg)] <= 1'b0;
                            sp_reg <= sp_reg + CW'(1);
                        end
                    end
                end
            end

            if (cmd.emit_art_step)
            begin
                emit_reg <= emit_reg + CW'(1);
                if (cut_reg[VW'(emit_reg)])
                begin
                    ov_reg <= 1'b1; kind_reg <= baf_pkg::REC_ART; st_reg <= baf_pkg::ST_OK;
                    lo_reg <= 4'(emit_reg); hi_reg <= '0; oo_reg <= '0; ol_reg <= '0;
                    op_reg <= '0; oc_reg <= 1'b0; oa_reg <= 1'b0; ol_last_reg <= 1'b0;
                end
            end

            if (cmd.emit_br_step)
            begin
                if (brm_reg[brow_reg][bcol_reg])
                begin
                    ov_reg <= 1'b1; kind_reg <= baf_pkg::REC_BRIDGE; st_reg <= baf_pkg::ST_OK;
                    lo_reg <= 4'(brow_reg); hi_reg <= 4'(bcol_reg); oo_reg <= '0;
                    ol_reg <= '0; op_reg <= '0; oc_reg <= 1'b0; oa_reg <= 1'b0;
                    ol_last_reg <= 1'b0;
                end
                if (bcol_reg == VW'(MAX_VERTICES - 1))
                begin
                    bcol_reg <= '0;
                    if (brow_reg == VW'(MAX_VERTICES - 1))
                        bdone_reg <= 1'b1;
                    else
                        brow_reg <= brow_reg + VW'(1);
                end
                else
                    bcol_reg <= bcol_reg + VW'(1);
            end

            if (cmd.emit_done)
            begin
                ov_reg <= 1'b1; kind_reg <= baf_pkg::REC_DONE; st_reg <= baf_pkg::ST_OK;
                lo_reg <= '0; hi_reg <= '0; oo_reg <= '0; ol_reg <= '0;
                op_reg <= '0; oc_reg <= 1'b0; oa_reg <= 1'b0; ol_last_reg <= 1'b1;
            end
        end
    end

endmodule

@@ sv/bridge_articulation_finder.sv @@
// ============================================================================
// bridge_articulation_finder
// Bridge and articulation point finder with explicit-stack low-link search.
// ============================================================================
//  channel  | signals                                 | dir
//  in       | in_valid, in_ready, action, vert_a/b    | in
//  out      | out_valid, out_ready, record fields     | out
//  cfg      | cfg_valid, cfg_ready, cfg_data          | in
//
//  Loads, clears and queries: one record each.
//  Build: each visited vertex scans the stored edges through the single edge
//  store read port (issue read, then evaluate) and is then popped; root
//  selection and cut output step over every vertex, and the bridge matrix
//  scan steps over all MAX_VERTICES^2 entries.
//  Output stalls hold the build sequence. Reset is asynchronous.
module bridge_articulation_finder
#(
    parameter int MAX_VERTICES = baf_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = baf_pkg::MAX_EDGES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        action,
    input  logic [3:0]        vert_a,
    input  logic [3:0]        vert_b,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        record_kind,
    output logic [1:0]        status,
    output logic [3:0]        vert_lo,
    output logic [3:0]        vert_hi,
    output logic signed [4:0] order,
    output logic [3:0]        low_link,
    output logic signed [4:0] parent,
    output logic              is_cut,
    output logic              bridge_answer,
    output logic              last
);

    logic [4:0]        nv_reg;
    baf_pkg::ctl_cmd_t cmd;
    baf_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= baf_pkg::NUM_VERT_RESET;
        else if (cfg_valid && cfg_ready)
            nv_reg <= cfg_data;
    end

    baf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .stat     (stat),
        .cmd      (cmd)
    );

    baf_datapath
    #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .action        (action),
        .vert_a        (vert_a),
        .vert_b        (vert_b),
        .num_vertices  (nv_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_kind   (record_kind),
        .status        (status),
        .vert_lo       (vert_lo),
        .vert_hi       (vert_hi),
        .order         (order),
        .low_link      (low_link),
        .parent        (parent),
        .is_cut        (is_cut),
        .bridge_answer (bridge_answer),
        .last          (last)
    );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the bridge and articulation point finder: random
// edge sets, builds and queries are predicted in place and compared per
// record; the configured vertex count is swept between phases.
// ============================================================================
module tb;

    typedef struct {
        logic [2:0] act;
        logic [3:0] va;
        logic [3:0] vb;
    } cmd_t;

    typedef struct {
        logic [2:0]        kind;
        logic [1:0]        st;
        logic [3:0]        lo;
        logic [3:0]        hi;
        logic signed [4:0] ord;
        logic [3:0]        lowv;
        logic signed [4:0] par;
        logic              cut;
        logic              ans;
        logic              lst;
    } rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] action = '0;
    logic [3:0] vert_a = '0;
    logic [3:0] vert_b = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [4:0] cfg_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [2:0] record_kind;
    logic [1:0] status;
    logic [3:0] vert_lo;
    logic [3:0] vert_hi;
    logic signed [4:0] order;
    logic [3:0] low_link;
    logic signed [4:0] parent;
    logic is_cut;
    logic bridge_answer;
    logic last;

    bridge_articulation_finder i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .vert_a(vert_a), .vert_b(vert_b),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_ready(out_ready),
        .record_kind(record_kind), .status(status), .vert_lo(vert_lo),
        .vert_hi(vert_hi), .order(order), .low_link(low_link), .parent(parent),
        .is_cut(is_cut), .bridge_answer(bridge_answer), .last(last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // graph model state
    logic [4:0] nv_reg;
    logic [3:0] ea [64];
    logic [3:0] eb [64];
    int ecnt;
    int ordt [16];
    int lowt [16];
    int part [16];
    bit cutf [16];
    int visits;

    cmd_t pending_cmds[$];
    rec_t expected_recs[$];
    int mismatches = 0;
    int cyc = 0;
    bit rx_hold = 1'b0;
    int tx_wait = 0;
    int rx_wait = 0;

    function automatic rec_t blank_rec(logic [2:0] k, logic [1:0] s);
        rec_t r;
        r.kind = k; r.st = s; r.lo = 0; r.hi = 0; r.ord = 0; r.lowv = 0;
        r.par = 0; r.cut = 0; r.ans = 0; r.lst = 0;
        return r;
    endfunction

    function automatic void reset_tables();
        for (int i = 0; i < 16; i++)
        begin
            ordt[i] = -1; lowt[i] = 0; part[i] = -1; cutf[i] = 0;
        end
        visits = 0;
    endfunction

    function automatic void run_search(int n);
        int sv [16]; int spe [16]; int snx [16]; int sch [16]; bit sart [16];
        int blo [16]; int bhi [16];
        int nb, sp, f, v, id, nbr, p, pv, t1, t2, j;
        rec_t r;
        nb = 0;
        for (int i = 0; i < 16; i++)
        begin
            ordt[i] = -1; part[i] = -1; cutf[i] = 0;
        end
        visits = 0;
        for (int root = 0; root < n; root++)
        begin
            if (ordt[root] != -1) continue;
            sp = 0;
            ordt[root] = visits; lowt[root] = visits; visits++;
            sv[0] = root; spe[0] = -1; snx[0] = 0; sch[0] = 0; sart[0] = 0; sp = 1;
            while (sp > 0)
            begin
                f = sp - 1; v = sv[f]; id = snx[f]; nbr = -1;
                while (id < ecnt)
                begin
                    if (id != spe[f] && ea[id] < n && eb[id] < n &&
                        (ea[id] == v || eb[id] == v))
                    begin
                        nbr = (ea[id] == v) ? eb[id] : ea[id];
                        break;
                    end
                    id++;
                end
                if (nbr < 0)
                begin
                    if (spe[f] == -1 && sch[f] > 1) sart[f] = 1;
                    cutf[v] = sart[f];
                    sp--;
                    if (sp > 0)
                    begin
                        p = sp - 1; pv = sv[p];
                        if (lowt[v] < lowt[pv]) lowt[pv] = lowt[v];
                        if (spe[p] != -1 && ordt[pv] <= lowt[v]) sart[p] = 1;
                        if (ordt[pv] < lowt[v] && nb < 16)
                        begin
                            blo[nb] = pv < v ? pv : v;
                            bhi[nb] = pv < v ? v : pv;
                            nb++;
                        end
                    end
                    continue;
                end
                snx[f] = id + 1;
                if (ordt[nbr] != -1)
                begin
                    if (ordt[nbr] < lowt[v]) lowt[v] = ordt[nbr];
                end
                else
                begin
                    part[nbr] = v; sch[f]++;
                    ordt[nbr] = visits; lowt[nbr] = visits; visits++;
                    sv[sp] = nbr; spe[sp] = id; snx[sp] = 0; sch[sp] = 0; sart[sp] = 0;
                    sp++;
                end
            end
        end
        for (int i = 0; i < n; i++)
            if (cutf[i])
            begin
                r = blank_rec(baf_pkg::REC_ART, baf_pkg::ST_OK); r.lo = 4'(i);
                expected_recs.push_back(r);
            end
        for (int i = 1; i < nb; i++)
        begin
            t1 = blo[i]; t2 = bhi[i]; j = i - 1;
            while (j >= 0 && (blo[j] > t1 || (blo[j] == t1 && bhi[j] > t2)))
            begin
                blo[j+1] = blo[j]; bhi[j+1] = bhi[j]; j--;
            end
            blo[j+1] = t1; bhi[j+1] = t2;
        end
        for (int i = 0; i < nb; i++)
        begin
            r = blank_rec(baf_pkg::REC_BRIDGE, baf_pkg::ST_OK);
            r.lo = 4'(blo[i]); r.hi = 4'(bhi[i]);
            expected_recs.push_back(r);
        end
        expected_recs.push_back(blank_rec(baf_pkg::REC_DONE, baf_pkg::ST_OK));
    endfunction

    function automatic void predict_graph_op(cmd_t c);
        int n, a, b, x, y;
        rec_t r;
        n = nv_reg < 1 ? 1 : (nv_reg > 16 ? 16 : nv_reg);
        a = c.va; b = c.vb;
        case (c.act)
            baf_pkg::ACT_ADD:
            begin
                r = blank_rec(baf_pkg::REC_ACK, baf_pkg::ST_OK);
                if (a >= n || b >= n) r.st = baf_pkg::ST_RANGE;
                else if (a == b) r.st = baf_pkg::ST_SELF;
                else if (ecnt >= 64) r.st = baf_pkg::ST_FULL;
                else
                begin
                    ea[ecnt] = 4'(a); eb[ecnt] = 4'(b); ecnt++;
                end
                expected_recs.push_back(r);
            end
            baf_pkg::ACT_BUILD: run_search(n);
            baf_pkg::ACT_BQUERY:
            begin
                r = blank_rec(baf_pkg::REC_BANS, baf_pkg::ST_OK);
                if (a >= n || b >= n) r.st = baf_pkg::ST_RANGE;
                else
                begin
                    x = a; y = b;
                    if (ordt[x] > ordt[y]) begin x = b; y = a; end
                    r.ans = ordt[x] < lowt[y];
                end
                expected_recs.push_back(r);
            end
            baf_pkg::ACT_VQUERY:
            begin
                r = blank_rec(baf_pkg::REC_VINFO, baf_pkg::ST_OK);
                if (a >= n) r.st = baf_pkg::ST_RANGE;
                else
                begin
                    r.ord = 5'(ordt[a]); r.lowv = 4'(lowt[a]); r.par = 5'(part[a]);
                    r.cut = cutf[a];
                end
                expected_recs.push_back(r);
            end
            baf_pkg::ACT_CLEAR:
            begin
                ecnt = 0; reset_tables();
                expected_recs.push_back(blank_rec(baf_pkg::REC_ACK, baf_pkg::ST_OK));
            end
            default: expected_recs.push_back(blank_rec(baf_pkg::REC_ACK, baf_pkg::ST_OK));
        endcase
        expected_recs[$].lst = 1'b1;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_valid <= 1'b0;
            tx_wait <= $urandom_range(0, 5);
        end
        else if (!in_valid && pending_cmds.size() > 0)
        begin
            if (tx_wait > 0)
                tx_wait <= tx_wait - 1;
            else
            begin
                action <= pending_cmds[0].act;
                vert_a <= pending_cmds[0].va;
                vert_b <= pending_cmds[0].vb;
                in_valid <= 1'b1;
                predict_graph_op(pending_cmds.pop_front());
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rec_t e;
        cyc <= cyc + 1;
        if (out_valid && out_ready)
        begin
            if (expected_recs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected record kind=%0d", record_kind);
            end
            else
            begin
                e = expected_recs.pop_front();
                if (record_kind !== e.kind || status !== e.st || vert_lo !== e.lo ||
                    vert_hi !== e.hi || order !== e.ord || low_link !== e.lowv ||
                    parent !== e.par || is_cut !== e.cut || bridge_answer !== e.ans ||
                    last !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp k%0d s%0d %0d/%0d o%0d l%0d p%0d c%0d a%0d e%0d",
                            e.kind, e.st, e.lo, e.hi, e.ord, e.lowv, e.par, e.cut,
                            e.ans, e.lst);
                        $display("         got k%0d s%0d %0d/%0d o%0d l%0d p%0d c%0d a%0d e%0d",
                            record_kind, status, vert_lo, vert_hi, order, low_link,
                            parent, is_cut, bridge_answer, last);
                    end
                end
            end
        end
        if (rx_hold)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            rx_wait = $urandom_range(0, 5);
            out_ready <= (rx_wait == 0);
        end
        else if (!out_ready)
        begin
            if (rx_wait > 0) rx_wait = rx_wait - 1;
            out_ready <= (rx_wait == 0);
        end
        if (cyc > 3000000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic cmd_t mk(logic [2:0] act, int a, int b);
        cmd_t c;
        c.act = act; c.va = 4'(a); c.vb = 4'(b);
        return c;
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || in_valid || expected_recs.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_vertex_count(logic [4:0] v);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        nv_reg = v;
    endtask

    // random phase: a graph of nv vertices, built and queried
    task automatic random_graph(int nitems, int nv);
        int k, lim;
        lim = nv < 1 ? 1 : nv;
        for (int i = 0; i < nitems; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 55)
                pending_cmds.push_back(mk(baf_pkg::ACT_ADD, $urandom_range(0, lim - 1),
                                          $urandom_range(0, lim - 1)));
            else if (k < 60)
                pending_cmds.push_back(mk(baf_pkg::ACT_ADD, $urandom_range(0, 15),
                                          $urandom_range(0, 15)));
            else if (k < 70)
                pending_cmds.push_back(mk(baf_pkg::ACT_BUILD, $urandom_range(0, 15),
                                          $urandom_range(0, 15)));
            else if (k < 80)
                pending_cmds.push_back(mk(baf_pkg::ACT_BQUERY, $urandom_range(0, 15),
                                          $urandom_range(0, 15)));
            else if (k < 93)
                pending_cmds.push_back(mk(baf_pkg::ACT_VQUERY, $urandom_range(0, 15),
                                          $urandom_range(0, 15)));
            else if (k < 96)
                pending_cmds.push_back(mk(baf_pkg::ACT_CLEAR, 0, 0));
            else
                pending_cmds.push_back(mk(3'($urandom_range(5, 7)), $urandom_range(0, 15),
                                          $urandom_range(0, 15)));
        end
        pending_cmds.push_back(mk(baf_pkg::ACT_BUILD, 0, 0));
    endtask

    initial
    begin
        int wait_n;
        logic [4:0] vc [6];
        vc = '{5'd16, 5'd6, 5'd2, 5'd9, 5'd1, 5'd16};
        nv_reg = baf_pkg::NUM_VERT_RESET;
        ecnt = 0;
        reset_tables();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: queries before build, ranges, self-loop, chain with bridges
        pending_cmds.push_back(mk(baf_pkg::ACT_BQUERY, 0, 15));
        pending_cmds.push_back(mk(baf_pkg::ACT_VQUERY, 15, 0));
        pending_cmds.push_back(mk(baf_pkg::ACT_ADD, 3, 3));
        pending_cmds.push_back(mk(baf_pkg::ACT_ADD, 0, 1));
        pending_cmds.push_back(mk(baf_pkg::ACT_ADD, 1, 2));
        pending_cmds.push_back(mk(baf_pkg::ACT_ADD, 2, 0));
        pending_cmds.push_back(mk(baf_pkg::ACT_ADD, 2, 3));
        pending_cmds.push_back(mk(baf_pkg::ACT_ADD, 3, 4));
        pending_cmds.push_back(mk(baf_pkg::ACT_ADD, 4, 3));
        pending_cmds.push_back(mk(baf_pkg::ACT_ADD, 15, 14));
        pending_cmds.push_back(mk(baf_pkg::ACT_BUILD, 0, 0));
        pending_cmds.push_back(mk(baf_pkg::ACT_VQUERY, 3, 0));
        pending_cmds.push_back(mk(baf_pkg::ACT_VQUERY, 15, 0));
        pending_cmds.push_back(mk(baf_pkg::ACT_BQUERY, 3, 2));
        pending_cmds.push_back(mk(baf_pkg::ACT_BQUERY, 14, 15));
        pending_cmds.push_back(mk(3'd7, 15, 15));
        pending_cmds.push_back(mk(baf_pkg::ACT_CLEAR, 0, 0));
        wait_idle();

        // store full, then shrink count so stored edges fall out of range
        for (int i = 0; i < 66; i++)
            pending_cmds.push_back(mk(baf_pkg::ACT_ADD, i % 16, (i + 1 + i / 16) % 16));
        wait_idle();
        write_vertex_count(5'd0);
        pending_cmds.push_back(mk(baf_pkg::ACT_ADD, 0, 1));
        pending_cmds.push_back(mk(baf_pkg::ACT_BUILD, 0, 0));
        pending_cmds.push_back(mk(baf_pkg::ACT_VQUERY, 0, 0));
        wait_idle();
        write_vertex_count(5'd31);
        pending_cmds.push_back(mk(baf_pkg::ACT_BUILD, 0, 0));
        pending_cmds.push_back(mk(baf_pkg::ACT_CLEAR, 0, 0));
        wait_idle();

        // random phases across vertex counts
        foreach (vc[i])
        begin
            write_vertex_count(vc[i]);
            random_graph(60, vc[i]);
            if (i == 3)
            begin
                wait_n = 0;
                rx_hold = 1'b1;
                while (wait_n < 400)
                begin
                    @(posedge clk);
                    wait_n++;
                end
                rx_hold = 1'b0;
            end
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0 && expected_recs.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
